/* hdl/rpc_pkg.sv */
// ----------------------------------------------------------------------------
// rpc_pkg: shared types and constants of the rectangular/polar converter
// Holds datapath widths, the arc tangent table and the per-cell work record.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int XY_W       = 34;
  localparam int Z_W        = 26;
  localparam int SQ_W       = 32;
  localparam int FRAC_BITS  = 14;
  localparam int SQRT_STEPS = 16;
  localparam int MAX_STEPS  = 24;

  localparam logic signed [Z_W-1:0] DEG90      = 26'sd5898240;
  localparam logic [29:0]           INV_GAIN   = 30'd652032874;
  localparam logic [15:0]           MAG_LIMIT  = 16'd46341;
  localparam logic signed [16:0]    RECT_LIMIT = 17'sd46341;
  localparam logic signed [16:0]    PH_LIMIT   = 17'sd23040;
  localparam logic signed [16:0]    PH_WRAP    = 17'sd46080;

  localparam logic [21:0] ATAN_TAB [MAX_STEPS] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef enum logic {
    MODE_TO_POLAR = 1'b0,
    MODE_TO_RECT  = 1'b1
  } rpc_mode_t;

  typedef struct packed {
    rpc_mode_t              mode;
    logic                   zero;
    logic [15:0]            pa;
    logic [15:0]            pb;
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [SQ_W-1:0]        rem;
    logic [SQ_W-1:0]        root;
  } rpc_work_t;

endpackage

/* hdl/rpc_prep.sv */
// ----------------------------------------------------------------------------
// rpc_prep: input stages of the converter
// Squares, gain-compensated magnitude, phase wrap, then quadrant setup.
// ----------------------------------------------------------------------------
module rpc_prep import rpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_real_in,
  input  logic signed [15:0] in_imag_in,
  input  logic [15:0]        in_magnitude_in,
  input  logic signed [15:0] in_phase_in,
  input  logic               down_ready,
  output logic               down_valid,
  output rpc_work_t          down_work
);

  logic               v1_r, v2_r, rdy1, rdy2;
  rpc_mode_t          mode1_r;
  logic signed [15:0] re1_r, im1_r, ph1_r;
  logic [15:0]        mag1_r;
  logic [30:0]        sqre1_r, sqim1_r;
  logic [29:0]        x01_r;
  rpc_work_t          work2_r, work_nxt;

  logic signed [31:0] re_sq, im_sq;
  logic [45:0]        x0_full;
  logic signed [16:0] ph_ext, ph_w;

  logic [SQ_W-1:0]        n_sum;
  logic signed [XY_W-1:0] rx, ry, x0s;
  logic signed [Z_W-1:0]  z1;

  assign rdy2       = !v2_r || down_ready;
  assign rdy1       = !v1_r || rdy2;
  assign in_stall   = !rdy1;
  assign down_valid = v2_r;
  assign down_work  = work2_r;

  assign re_sq   = 32'(in_real_in) * 32'(in_real_in);
  assign im_sq   = 32'(in_imag_in) * 32'(in_imag_in);
  assign x0_full = 46'(in_magnitude_in) * 46'(INV_GAIN);
  assign ph_ext  = 17'(in_phase_in);

  always_comb begin
    ph_w = ph_ext;
    if (ph_ext > PH_LIMIT) begin
      ph_w = ph_ext - PH_WRAP;
    end else if (ph_ext < -PH_LIMIT) begin
      ph_w = ph_ext + PH_WRAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      mode1_r <= rpc_mode_t'(in_mode);
      re1_r   <= in_real_in;
      im1_r   <= in_imag_in;
      mag1_r  <= (in_magnitude_in > MAG_LIMIT) ? MAG_LIMIT : in_magnitude_in;
      ph1_r   <= 16'(ph_w);
      sqre1_r <= re_sq[30:0];
      sqim1_r <= im_sq[30:0];
      x01_r   <= x0_full[45:16];
    end
    if (rdy2) begin
      work2_r <= work_nxt;
    end
  end

  assign n_sum = SQ_W'(sqre1_r) + SQ_W'(sqim1_r);
  assign rx    = XY_W'(re1_r) <<< FRAC_BITS;
  assign ry    = XY_W'(im1_r) <<< FRAC_BITS;
  assign x0s   = XY_W'(x01_r);
  assign z1    = Z_W'(ph1_r) <<< 9;

  always_comb begin
    work_nxt      = '0;
    work_nxt.mode = mode1_r;
    work_nxt.zero = (re1_r == 16'sd0) && (im1_r == 16'sd0);
    work_nxt.rem  = n_sum;
    work_nxt.root = '0;
    if (mode1_r == MODE_TO_POLAR) begin
      work_nxt.pa = re1_r;
      work_nxt.pb = im1_r;
      if (rx < 0) begin
        if (ry >= 0) begin
          work_nxt.x = ry;
          work_nxt.y = -rx;
          work_nxt.z = DEG90;
        end else begin
          work_nxt.x = -ry;
          work_nxt.y = rx;
          work_nxt.z = -DEG90;
        end
      end else begin
        work_nxt.x = rx;
        work_nxt.y = ry;
        work_nxt.z = '0;
      end
    end else begin
      work_nxt.pa = mag1_r;
      work_nxt.pb = ph1_r;
      if (z1 > DEG90) begin
        work_nxt.x = '0;
        work_nxt.y = x0s;
        work_nxt.z = z1 - DEG90;
      end else if (z1 < -DEG90) begin
        work_nxt.x = '0;
        work_nxt.y = -x0s;
        work_nxt.z = z1 + DEG90;
      end else begin
        work_nxt.x = x0s;
        work_nxt.y = '0;
        work_nxt.z = z1;
      end
    end
  end

endmodule

/* hdl/rpc_cell.sv */
// ----------------------------------------------------------------------------
// rpc_cell: one cell of the converter chain
// A CORDIC micro-rotation if DO_ROT, a restoring square root step if DO_SQRT.
// ----------------------------------------------------------------------------
module rpc_cell import rpc_pkg::*; #(
  parameter int IDX     = 0,
  parameter bit DO_ROT  = 1'b1,
  parameter bit DO_SQRT = 1'b1
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  input  rpc_work_t up_work,
  output logic      up_ready,
  input  logic      down_ready,
  output logic      down_valid,
  output rpc_work_t down_work
);

  localparam int                    SQ_SH  = (IDX < SQRT_STEPS) ? 30 - 2 * IDX : 0;
  localparam logic [SQ_W-1:0]       SQ_BIT = SQ_W'(1) << SQ_SH;
  localparam logic signed [Z_W-1:0] ARC    = Z_W'(ATAN_TAB[IDX]);

  logic                   v_r;
  rpc_work_t              work_r, work_nxt;
  logic signed [XY_W-1:0] x_in, y_in, dx, dy;
  logic signed [Z_W-1:0]  z_in;
  logic                   sub;
  logic [SQ_W:0]          trial;

  assign up_ready   = !v_r || down_ready;
  assign down_valid = v_r;
  assign down_work  = work_r;

  assign x_in  = up_work.x;
  assign y_in  = up_work.y;
  assign z_in  = up_work.z;
  assign dx    = y_in >>> IDX;
  assign dy    = x_in >>> IDX;
  assign sub   = (up_work.mode == MODE_TO_RECT) ? !z_in[Z_W-1] : y_in[XY_W-1];
  assign trial = {1'b0, up_work.root} + {1'b0, SQ_BIT};

  always_comb begin
    work_nxt = up_work;
    if (DO_ROT) begin
      if (sub) begin
        work_nxt.x = x_in - dx;
        work_nxt.y = y_in + dy;
        work_nxt.z = z_in - ARC;
      end else begin
        work_nxt.x = x_in + dx;
        work_nxt.y = y_in - dy;
        work_nxt.z = z_in + ARC;
      end
    end
    if (DO_SQRT) begin
      if ({1'b0, up_work.rem} >= trial) begin
        work_nxt.rem  = up_work.rem - trial[SQ_W-1:0];
        work_nxt.root = (up_work.root >> 1) + SQ_BIT;
      end else begin
        work_nxt.root = up_work.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      work_r <= work_nxt;
    end
  end

endmodule

/* hdl/rpc_post.sv */
// ----------------------------------------------------------------------------
// rpc_post: output stage of the converter
// Rounds and clamps the chain results and selects fields by mode.
// ----------------------------------------------------------------------------
module rpc_post import rpc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  input  rpc_work_t          up_work,
  output logic               up_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_real_out,
  output logic signed [16:0] out_imag_out,
  output logic [15:0]        out_magnitude_out,
  output logic signed [15:0] out_phase_out
);

  logic                   v_r;
  logic signed [16:0]     re_r, im_r, re_nxt, im_nxt;
  logic [15:0]            mag_r, mag_nxt;
  logic signed [15:0]     ph_r, ph_nxt;
  logic signed [XY_W-1:0] xr, yr;
  logic signed [Z_W-1:0]  zr;
  logic signed [16:0]     x_cl, y_cl, z_cl;
  logic [16:0]            mag_rnd;

  assign up_ready          = !v_r || !out_stall;
  assign out_valid         = v_r;
  assign out_real_out      = re_r;
  assign out_imag_out      = im_r;
  assign out_magnitude_out = mag_r;
  assign out_phase_out     = ph_r;

  assign xr = (up_work.x + XY_W'(8192)) >>> FRAC_BITS;
  assign yr = (up_work.y + XY_W'(8192)) >>> FRAC_BITS;
  assign zr = (up_work.z + Z_W'(256)) >>> 9;

  always_comb begin
    if (xr > XY_W'(RECT_LIMIT)) begin
      x_cl = RECT_LIMIT;
    end else if (xr < -XY_W'(RECT_LIMIT)) begin
      x_cl = -RECT_LIMIT;
    end else begin
      x_cl = 17'(xr);
    end
    if (yr > XY_W'(RECT_LIMIT)) begin
      y_cl = RECT_LIMIT;
    end else if (yr < -XY_W'(RECT_LIMIT)) begin
      y_cl = -RECT_LIMIT;
    end else begin
      y_cl = 17'(yr);
    end
    if (zr > Z_W'(PH_LIMIT)) begin
      z_cl = PH_LIMIT;
    end else if (zr < -Z_W'(PH_LIMIT)) begin
      z_cl = -PH_LIMIT;
    end else begin
      z_cl = 17'(zr);
    end
  end

  assign mag_rnd = up_work.root[16:0] + 17'(up_work.rem > up_work.root);

  always_comb begin
    if (up_work.mode == MODE_TO_POLAR) begin
      re_nxt  = 17'($signed(up_work.pa));
      im_nxt  = 17'($signed(up_work.pb));
      mag_nxt = mag_rnd[15:0];
      ph_nxt  = up_work.zero ? 16'sd0 : 16'(z_cl);
    end else begin
      re_nxt  = x_cl;
      im_nxt  = y_cl;
      mag_nxt = up_work.pa;
      ph_nxt  = up_work.pb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      re_r  <= re_nxt;
      im_r  <= im_nxt;
      mag_r <= mag_nxt;
      ph_r  <= ph_nxt;
    end
  end

endmodule

/* hdl/rect_polar_converter.sv */
// ----------------------------------------------------------------------------
// rect_polar_converter: rectangular/polar conversion of complex values
// Input channel in_*: one request carries a mode and both operand forms.
//   Mode 0 takes in_real_in/in_imag_in and returns magnitude and phase;
//   mode 1 takes in_magnitude_in/in_phase_in and returns real and imag.
//   Every result carries both forms; phase is in 1/128 degree units.
// Output channel out_*: one result per request, in request order.
// Structure: two input stages (squares, gain multiply, quadrant setup),
//   a chain of max(ITERATIONS, 16) cells, one CORDIC rotation per cell in
//   the first ITERATIONS and one square root bit per cell in the first 16,
//   then a rounding and clamping output register; max(ITERATIONS, 16) + 3
//   register stages in all.
// Throughput: one request per cycle while not stalled; each stage advances
//   when empty or when the next stage advances; bubbles close up under stall.
// Stall: a stalled result holds in the output register; in_stall rises only
//   once every stage holds a request.
// Reset: rst_n clears all stage valid flags; no results are pending after it.
// ----------------------------------------------------------------------------
module rect_polar_converter import rpc_pkg::*; #(
  parameter int ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [15:0] in_real_in,
  input  logic signed [15:0] in_imag_in,
  input  logic [15:0]        in_magnitude_in,
  input  logic signed [15:0] in_phase_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_real_out,
  output logic signed [16:0] out_imag_out,
  output logic [15:0]        out_magnitude_out,
  output logic signed [15:0] out_phase_out
);

  localparam int NCELL = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS;

  rpc_work_t work [NCELL+1];
  logic      vld  [NCELL+1];
  logic      rdy  [NCELL+1];

  rpc_prep u_prep (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_real_in      (in_real_in),
    .in_imag_in      (in_imag_in),
    .in_magnitude_in (in_magnitude_in),
    .in_phase_in     (in_phase_in),
    .down_ready      (rdy[0]),
    .down_valid      (vld[0]),
    .down_work       (work[0])
  );

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    rpc_cell #(
      .IDX     (k),
      .DO_ROT  (k < ITERATIONS),
      .DO_SQRT (k < SQRT_STEPS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .up_valid   (vld[k]),
      .up_work    (work[k]),
      .up_ready   (rdy[k]),
      .down_ready (rdy[k+1]),
      .down_valid (vld[k+1]),
      .down_work  (work[k+1])
    );
  end

  rpc_post u_post (
    .clk               (clk),
    .rst_n             (rst_n),
    .up_valid          (vld[NCELL]),
    .up_work           (work[NCELL]),
    .up_ready          (rdy[NCELL]),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_real_out      (out_real_out),
    .out_imag_out      (out_imag_out),
    .out_magnitude_out (out_magnitude_out),
    .out_phase_out     (out_phase_out)
  );

`ifndef SYNTHESIS
  a_mag_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_magnitude_out <= MAG_LIMIT))
    else $error("magnitude out of range");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (17'(out_phase_out) <= PH_LIMIT && 17'(out_phase_out) >= -PH_LIMIT))
    else $error("phase out of range");

  a_rect_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_real_out <= RECT_LIMIT && out_real_out >= -RECT_LIMIT &&
                   out_imag_out <= RECT_LIMIT && out_imag_out >= -RECT_LIMIT))
    else $error("rectangular part out of range");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while pipeline can advance");
`endif

endmodule

/* test/tb_rect_polar_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_polar_converter: self-checking bench for the rect/polar converter
// Drives requests in both modes: a directed set of edge cases first, then
// random requests. A scoreboard class computes each expected result in
// fixed point, queues it and compares every result in order. Both sides
// idle at random; one stretch runs without idling, and the sender waits for
// the pipeline to drain completely twice mid-run and once more at the end.
// ----------------------------------------------------------------------------
module tb_rect_polar_converter import rpc_pkg::*; ();

  localparam int ITER = 16;

  typedef struct packed {
    logic signed [16:0] re;
    logic signed [16:0] im;
    logic [15:0]        mag;
    logic signed [15:0] ph;
  } cplx_both_t;

  class conversion_board;
    int steps;
    int fails;
    int n_polar;
    int n_rect;
    int n_checked;
    longint arc_tab[24];
    cplx_both_t awaited[$];

    function new(int n);
      steps = n;
      fails = 0;
      n_polar = 0;
      n_rect = 0;
      n_checked = 0;
      arc_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                  14668, 7334, 3667, 1833, 917, 458, 229, 115,
                  57, 29, 14, 7, 4, 2, 1, 0};
    endfunction

    function longint clamp(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function longint sqrt_nearest(longint unsigned n);
      longint unsigned res;
      longint unsigned bitv;
      longint unsigned rem;
      res = 0;
      bitv = 64'd1 << 32;
      rem = n;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (rem >= res + bitv) begin
          rem = rem - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      if (n - res * res > res) res = res + 1;
      return longint'(res);
    endfunction

    function cplx_both_t convert(rpc_mode_t m, logic signed [15:0] re_i,
                                 logic signed [15:0] im_i, logic [15:0] mag_i,
                                 logic signed [15:0] ph_i);
      longint re, im, mag, ph, x, y, z, t, dx, dy, x0;
      longint quarter;
      int i;
      cplx_both_t r;
      quarter = 64'sd90 * 65536;
      if (m == MODE_TO_POLAR) begin
        re = re_i;
        im = im_i;
        mag = sqrt_nearest(longint'(re * re + im * im));
        if (re == 0 && im == 0) begin
          ph = 0;
        end else begin
          x = re * 16384;
          y = im * 16384;
          z = 0;
          if (x < 0) begin
            if (y >= 0) begin
              t = x; x = y; y = -t; z = quarter;
            end else begin
              t = x; x = -y; y = t; z = -quarter;
            end
          end
          for (i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
              x = x - dx; y = y + dy; z = z - arc_tab[i];
            end else begin
              x = x + dx; y = y - dy; z = z + arc_tab[i];
            end
          end
          ph = clamp((z + 256) >>> 9, 23040);
        end
      end else begin
        mag = mag_i;
        ph = ph_i;
        if (ph > 23040) ph = ph - 46080;
        else if (ph < -23040) ph = ph + 46080;
        x0 = (mag * 64'sd652032874) >>> 16;
        z = ph * 512;
        x = x0;
        y = 0;
        if (z > quarter) begin
          x = 0; y = x0; z = z - quarter;
        end else if (z < -quarter) begin
          x = 0; y = -x0; z = z + quarter;
        end
        for (i = 0; i < steps; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - arc_tab[i];
          end else begin
            x = x + dx; y = y - dy; z = z + arc_tab[i];
          end
        end
        re = clamp((x + 8192) >>> 14, 46341);
        im = clamp((y + 8192) >>> 14, 46341);
        if (mag > 46341) mag = 46341;
      end
      r.re = re[16:0];
      r.im = im[16:0];
      r.mag = mag[15:0];
      r.ph = ph[15:0];
      return r;
    endfunction

    function void note_request(rpc_mode_t m, logic signed [15:0] re_i,
                               logic signed [15:0] im_i, logic [15:0] mag_i,
                               logic signed [15:0] ph_i);
      awaited.push_back(convert(m, re_i, im_i, mag_i, ph_i));
      if (m == MODE_TO_POLAR) n_polar++;
      else n_rect++;
    endfunction

    task report(string msg);
      if (fails < 25) $display("mismatch: %s", msg);
      fails++;
    endtask

    task check_result(cplx_both_t got);
      cplx_both_t want;
      if (awaited.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = awaited.pop_front();
        n_checked++;
        if (got.re !== want.re)
          report($sformatf("real_out got %0d want %0d", got.re, want.re));
        if (got.im !== want.im)
          report($sformatf("imag_out got %0d want %0d", got.im, want.im));
        if (got.mag !== want.mag)
          report($sformatf("magnitude_out got %0d want %0d", got.mag, want.mag));
        if (got.ph !== want.ph)
          report($sformatf("phase_out got %0d want %0d", got.ph, want.ph));
      end
    endtask

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_mode = 1'b0;
  logic signed [15:0] in_real_in = '0;
  logic signed [15:0] in_imag_in = '0;
  logic [15:0]        in_magnitude_in = '0;
  logic signed [15:0] in_phase_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] out_real_out;
  logic signed [16:0] out_imag_out;
  logic [15:0]        out_magnitude_out;
  logic signed [15:0] out_phase_out;

  logic               steady = 1'b0;
  conversion_board    board;

  rect_polar_converter #(.ITERATIONS(ITER)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_real_in        (in_real_in),
    .in_imag_in        (in_imag_in),
    .in_magnitude_in   (in_magnitude_in),
    .in_phase_in       (in_phase_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_real_out      (out_real_out),
    .out_imag_out      (out_imag_out),
    .out_magnitude_out (out_magnitude_out),
    .out_phase_out     (out_phase_out)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 21);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        board.note_request(rpc_mode_t'(in_mode), in_real_in, in_imag_in,
                           in_magnitude_in, in_phase_in);
      if (out_valid && !out_stall)
        board.check_result(cplx_both_t'{out_real_out, out_imag_out,
                                        out_magnitude_out, out_phase_out});
    end
  end

  task automatic send(rpc_mode_t m, logic signed [15:0] re, logic signed [15:0] im,
                      logic [15:0] mag, logic signed [15:0] ph);
    if (!steady) begin
      while ($urandom_range(0, 99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    in_mode         <= m;
    in_real_in      <= re;
    in_imag_in      <= im;
    in_magnitude_in <= mag;
    in_phase_in     <= ph;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every outstanding request has produced its result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic logic signed [15:0] rect_part();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 16'($urandom);
    if (sel < 75) return 16'(int'($urandom_range(0, 16)) - 8);
    case ($urandom_range(0, 5))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic logic [15:0] mag_part();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) return 16'($urandom_range(0, 46341));
    if (sel < 90) return 16'($urandom_range(46342, 65535));
    return 16'($urandom_range(0, 4));
  endfunction

  function automatic logic signed [15:0] phase_part();
    int sel;
    int k;
    sel = $urandom_range(0, 99);
    if (sel < 80) return 16'(int'($urandom_range(0, 46080)) - 23040);
    if (sel < 90) return 16'($urandom);
    k = int'($urandom_range(0, 4)) - 2;
    return 16'(k * 11520 + int'($urandom_range(0, 4)) - 2);
  endfunction

  initial begin
    #5_000_000;
    $display("tb_rect_polar_converter: FAIL");
    $finish;
  end

  initial begin
    rpc_mode_t m;
    int n;
    board = new(ITER);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // rectangular to polar corners
    send(MODE_TO_POLAR, 16'sd0, 16'sd0, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, 16'sd32767, 16'sd0, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, -16'sd32768, 16'sd0, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, 16'sd0, 16'sd32767, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, 16'sd0, -16'sd32768, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, -16'sd32768, -16'sd32768, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, 16'sd32767, 16'sd32767, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, -16'sd32768, 16'sd32767, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, -16'sd1, 16'sd0, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, -16'sd1, -16'sd1, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, 16'sd1, -16'sd1, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, -16'sd5, 16'sd0, 16'($urandom), 16'($urandom));
    send(MODE_TO_POLAR, 16'sd3, 16'sd4, 16'($urandom), 16'($urandom));
    // polar to rectangular corners, wrap and saturation
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd0, 16'sd0);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd46341, 16'sd0);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd65535, 16'sd0);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd46341, 16'sd23040);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd46341, -16'sd23040);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd1000, 16'sd11520);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd1000, -16'sd11520);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd1000, 16'sd32767);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd1000, -16'sd32768);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd46341, 16'sd23041);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd20000, 16'sd5760);
    send(MODE_TO_RECT, 16'($urandom), 16'($urandom), 16'd65535, 16'sd16000);
    drain();

    for (n = 0; n < 1200; n++) begin
      if (n == 400) steady <= 1'b1;
      if (n == 700) steady <= 1'b0;
      if (n == 800) drain();
      m = rpc_mode_t'($urandom_range(0, 1));
      send(m, rect_part(), rect_part(), mag_part(), phase_part());
    end
    in_valid <= 1'b0;

    do @(posedge clk); while (board.pending() != 0);
    repeat (ITER + 8) @(posedge clk);

    $display("covered %0d rect-to-polar and %0d polar-to-rect requests, %0d results checked",
             board.n_polar, board.n_rect, board.n_checked);
    if (board.fails == 0) begin
      $display("tb_rect_polar_converter: PASS");
    end else begin
      $display("tb_rect_polar_converter: FAIL");
    end
    $finish;
  end

endmodule
